// ===== rtl/stable_priority_queue_with_attachments_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the queue modules.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_WITH_ATTACHMENTS_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_WITH_ATTACHMENTS_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the priority queue modules.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int DEF_QUEUE_DEPTH    = 8;
  localparam int DEF_BAGS_PER_ENTRY = 8;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ATTACH = 2'd1;
  localparam logic [1:0] REQ_POP    = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAGS_FULL = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] flight_tag;
    logic [3:0]  priority_req;
    logic [31:0] bag_tag;
  } spq_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_flight_tag;
    logic [3:0]  out_priority;
    logic [3:0]  out_bag_count;
    logic [31:0] out_bag_tag;
    logic        bag_valid;
    logic        last;
  } spq_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic bag_step;
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_bags;
    logic bag_last;
  } spq_sts_t;

endpackage

// ===== rtl/stable_priority_queue_with_attachments.sv =====
// ---------------------------------------------------------------------------
// stable_priority_queue_with_attachments
// Sorted priority queue of tagged entries, each carrying a list of bag tags.
// ---------------------------------------------------------------------------
// A request beat is taken on a clock edge with start high and busy low. Insert,
// attach and a pop of an empty queue give one result beat, computed in the EXEC
// state and strobed from the result register; busy drops in that same cycle, so
// the next request can be taken while that beat is shown. A pop of an entry
// with N bags gives a header beat and then one bag beat per cycle; the bag beats
// come one per cycle because the bag store is a single-port-read RAM with
// registered data. The unused request code gives no beat and also frees the block
// when it leaves the EXEC state. Every result beat is shown on out_res for exactly
// one cycle with out_valid high, and the receiver must take it then: there is no
// back-pressure. Lower priority numbers leave first, equal priorities leave in
// arrival order, and the queue needs no clearing pass after reset.
// ---------------------------------------------------------------------------
module stable_priority_queue_with_attachments
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int BAGS_PER_ENTRY = DEF_BAGS_PER_ENTRY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_req_t in_req,
  output logic     out_valid,
  output spq_res_t out_res
);

  // The controller sequences each request; the datapath holds the queue state.
  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  // Entries live in sorted lanes; bag tags sit in a RAM indexed by a fixed slot id,
  // so reordering the queue never moves any bag data.
  spq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .BAGS_PER_ENTRY(BAGS_PER_ENTRY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

endmodule

// ===== rtl/spq_ram.sv =====
// ---------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/spq_ctrl.sv =====
// ---------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: accepts a beat, runs it, then for a pop with bags steps out the bag results.
// ---------------------------------------------------------------------------
`include "stable_priority_queue_with_attachments_assert.svh"

module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_sts_t sts,
  output spq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_BAGS = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = sts.pop_bags ? S_BAGS : S_IDLE;
      S_BAGS: if (sts.bag_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && start;
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.bag_step = (state_r == S_BAGS);

  `SPQ_ASSERT_NEXT(a_bags_end, (state_r == S_BAGS) && sts.bag_last, state_r == S_IDLE, "bag run did not end")

endmodule

// ===== rtl/spq_dp.sv =====
// ---------------------------------------------------------------------------
// spq_dp
// Queue datapath: sorted entry lanes, slot allocation, bag RAM and result register.
// ---------------------------------------------------------------------------
`include "stable_priority_queue_with_attachments_assert.svh"

module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
  parameter int BAGS_PER_ENTRY = DEF_BAGS_PER_ENTRY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  spq_req_t in_req,
  input  spq_cmd_t cmd,
  output spq_sts_t sts,
  output logic     out_valid,
  output spq_res_t out_res
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = $clog2(BAGS_PER_ENTRY + 1);
  localparam int AW = $clog2(QUEUE_DEPTH * BAGS_PER_ENTRY);

  spq_req_t        req_r;
  logic [OW-1:0]   occ_r, occ_nxt;
  logic [QUEUE_DEPTH-1:0] free_r, free_nxt;
  logic [31:0]     tag_r [QUEUE_DEPTH];
  logic [3:0]      pri_r [QUEUE_DEPTH];
  logic [CW-1:0]   cnt_r [QUEUE_DEPTH];
  logic [PW-1:0]   pid_r [QUEUE_DEPTH];
  logic [31:0]     tag_nxt [QUEUE_DEPTH];
  logic [3:0]      pri_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   cnt_nxt [QUEUE_DEPTH];
  logic [PW-1:0]   pid_nxt [QUEUE_DEPTH];
  logic [31:0]     hd_tag_r;
  logic [3:0]      hd_pri_r;
  logic [CW-1:0]   hd_cnt_r;
  logic [PW-1:0]   hd_pid_r;
  logic [CW-1:0]   bidx_r;
  logic            out_valid_r, out_valid_nxt;
  spq_res_t        out_res_r, out_res_nxt;

  logic [QUEUE_DEPTH-1:0] gtv;
  logic            m_hit, a_hit;
  logic [PW-1:0]   m_idx, a_pid;
  logic            full, empty;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_rdata;
  logic [CW-1:0]   bidx_inc;

  assign full     = (occ_r == OW'(QUEUE_DEPTH));
  assign empty    = (occ_r == '0);
  assign bidx_inc = bidx_r + CW'(1);

  // Lane compares: entries behind the insert point, first tag match, first free slot.
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    a_hit = 1'b0;
    a_pid = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gtv[i] = (OW'(i) < occ_r) && (pri_r[i] > req_r.priority_req);
      if (!m_hit && (OW'(i) < occ_r) && (tag_r[i] == req_r.flight_tag)) begin
        m_hit = 1'b1;
        m_idx = PW'(i);
      end
      if (!a_hit && free_r[i]) begin
        a_hit = 1'b1;
        a_pid = PW'(i);
      end
    end
  end

  assign ram_we    = cmd.exec && (req_r.req_type == REQ_ATTACH) && m_hit &&
                     (cnt_r[m_idx] < CW'(BAGS_PER_ENTRY));
  assign ram_waddr = AW'(pid_r[m_idx]) * AW'(BAGS_PER_ENTRY) + AW'(cnt_r[m_idx]);
  assign ram_re    = cmd.exec || cmd.bag_step;
  assign ram_raddr = cmd.exec ? AW'(pid_r[0]) * AW'(BAGS_PER_ENTRY)
                              : AW'(hd_pid_r) * AW'(BAGS_PER_ENTRY) + AW'(bidx_inc);

  assign sts.pop_bags = (req_r.req_type == REQ_POP) && !empty && (cnt_r[0] != '0);
  assign sts.bag_last = (bidx_inc == hd_cnt_r);

  always_comb begin
    occ_nxt       = occ_r;
    free_nxt      = free_r;
    tag_nxt       = tag_r;
    pri_nxt       = pri_r;
    cnt_nxt       = cnt_r;
    pid_nxt       = pid_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    out_res_nxt.last = 1'b1;
    if (cmd.exec) begin
      unique case (req_r.req_type)
        REQ_INSERT: begin
          out_valid_nxt = 1'b1;
          if (full) begin
            out_res_nxt.status = ST_FULL;
          end else begin
            out_res_nxt.status = ST_OK;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if ((i > 0) && gtv[(i > 0) ? i - 1 : 0]) begin
                tag_nxt[i] = tag_r[(i > 0) ? i - 1 : 0];
                pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
                cnt_nxt[i] = cnt_r[(i > 0) ? i - 1 : 0];
                pid_nxt[i] = pid_r[(i > 0) ? i - 1 : 0];
              end else if (gtv[i] || (OW'(i) == occ_r)) begin
                tag_nxt[i] = req_r.flight_tag;
                pri_nxt[i] = req_r.priority_req;
                cnt_nxt[i] = '0;
                pid_nxt[i] = a_pid;
              end
            end
            free_nxt[a_pid] = 1'b0;
            occ_nxt = occ_r + OW'(1);
          end
        end
        REQ_ATTACH: begin
          out_valid_nxt = 1'b1;
          if (!m_hit) begin
            out_res_nxt.status = ST_NOT_FOUND;
          end else if (!ram_we) begin
            out_res_nxt.status = ST_BAGS_FULL;
          end else begin
            out_res_nxt.status = ST_OK;
            cnt_nxt[m_idx] = cnt_r[m_idx] + CW'(1);
          end
        end
        REQ_POP: begin
          out_valid_nxt = 1'b1;
          if (empty) begin
            out_res_nxt.status = ST_EMPTY;
          end else begin
            out_res_nxt.status         = ST_OK;
            out_res_nxt.out_flight_tag = tag_r[0];
            out_res_nxt.out_priority   = pri_r[0];
            out_res_nxt.out_bag_count  = 4'(cnt_r[0]);
            out_res_nxt.last           = (cnt_r[0] == '0);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              tag_nxt[i] = tag_r[i + 1];
              pri_nxt[i] = pri_r[i + 1];
              cnt_nxt[i] = cnt_r[i + 1];
              pid_nxt[i] = pid_r[i + 1];
            end
            free_nxt[pid_r[0]] = 1'b1;
            occ_nxt = occ_r - OW'(1);
          end
        end
        default: out_valid_nxt = 1'b0;
      endcase
    end else if (cmd.bag_step) begin
      out_valid_nxt              = 1'b1;
      out_res_nxt.status         = ST_OK;
      out_res_nxt.out_flight_tag = hd_tag_r;
      out_res_nxt.out_priority   = hd_pri_r;
      out_res_nxt.out_bag_count  = 4'(hd_cnt_r);
      out_res_nxt.out_bag_tag    = ram_rdata;
      out_res_nxt.bag_valid      = 1'b1;
      out_res_nxt.last           = sts.bag_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      free_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r     <= tag_nxt;
    pri_r     <= pri_nxt;
    cnt_r     <= cnt_nxt;
    pid_r     <= pid_nxt;
    out_res_r <= out_res_nxt;
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.exec) begin
      hd_tag_r <= tag_r[0];
      hd_pri_r <= pri_r[0];
      hd_cnt_r <= cnt_r[0];
      hd_pid_r <= pid_r[0];
      bidx_r   <= '0;
    end else if (cmd.bag_step) begin
      bidx_r <= bidx_inc;
    end
  end

  spq_ram #(
    .WIDTH(32),
    .DEPTH(QUEUE_DEPTH * BAGS_PER_ENTRY)
  ) u_bag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(req_r.bag_tag),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `SPQ_ASSERT_ALWAYS(a_occ_range, occ_r <= OW'(QUEUE_DEPTH), "occupancy beyond depth")
  `SPQ_ASSERT_ALWAYS(a_free_count, $countones(free_r) == (QUEUE_DEPTH - int'(occ_r)), "slot map out of step with occupancy")
  `SPQ_ASSERT_NEXT(a_bag_last, cmd.bag_step && sts.bag_last, out_valid && out_res.last && out_res.bag_valid, "final bag beat not marked last")

endmodule

// ===== sim/stable_priority_queue_with_attachments_test.sv =====
// ---------------------------------------------------------------------------
// stable_priority_queue_with_attachments_test
// Self-checking bench: drives insert, attach, pop and unused-code requests with
// random gaps, predicts every result beat with a behavioral queue and checks each
// beat in order as it leaves the block.
// ---------------------------------------------------------------------------
module stable_priority_queue_with_attachments_test;
  import spq_pkg::*;

  localparam int DEPTH = DEF_QUEUE_DEPTH;
  localparam int BAGS  = DEF_BAGS_PER_ENTRY;
  // Unused request code; the block must ignore it.
  localparam logic [1:0] REQ_NONE = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_req_t in_req = '0;
  logic     out_valid;
  spq_res_t out_res;

  stable_priority_queue_with_attachments dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #6 clk = ~clk;

  // Behavioral copy of the queue contents, kept in sorted order.
  logic [31:0] q_tag   [DEPTH];
  logic [3:0]  q_pri   [DEPTH];
  logic [3:0]  q_nbags [DEPTH];
  logic [31:0] q_bags  [DEPTH][BAGS];
  int          q_fill;

  spq_req_t pending_reqs[$];
  spq_res_t expected_beats[$];
  int       fail_count;
  bit       calm;        // no idling in the last part of the run
  bit       stim_done;
  int       send_gap;

  // One beat of result for a request that only reports a status.
  function automatic spq_res_t status_beat(logic [2:0] st);
    spq_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Applies one accepted request to the model queue and queues its beats.
  task automatic predict_queue(spq_req_t rq);
    int i;
    spq_res_t r;
    case (rq.req_type)
      REQ_INSERT: begin
        if (q_fill >= DEPTH) begin
          expected_beats.push_back(status_beat(ST_FULL));
        end else begin
          i = q_fill;
          // Stable order: the new entry goes behind all of equal priority.
          while (i > 0 && q_pri[i-1] > rq.priority_req) begin
            q_tag[i] = q_tag[i-1];
            q_pri[i] = q_pri[i-1];
            q_nbags[i] = q_nbags[i-1];
            q_bags[i] = q_bags[i-1];
            i--;
          end
          q_tag[i] = rq.flight_tag;
          q_pri[i] = rq.priority_req;
          q_nbags[i] = '0;
          q_fill++;
          expected_beats.push_back(status_beat(ST_OK));
        end
      end
      REQ_ATTACH: begin
        for (i = 0; i < q_fill; i++) begin
          if (q_tag[i] == rq.flight_tag) break;
        end
        if (i == q_fill) begin
          expected_beats.push_back(status_beat(ST_NOT_FOUND));
        end else if (q_nbags[i] >= BAGS) begin
          expected_beats.push_back(status_beat(ST_BAGS_FULL));
        end else begin
          q_bags[i][q_nbags[i]] = rq.bag_tag;
          q_nbags[i]++;
          expected_beats.push_back(status_beat(ST_OK));
        end
      end
      REQ_POP: begin
        if (q_fill == 0) begin
          expected_beats.push_back(status_beat(ST_EMPTY));
        end else begin
          // Header beat first, then one beat per attached bag.
          r = '0;
          r.status = ST_OK;
          r.out_flight_tag = q_tag[0];
          r.out_priority = q_pri[0];
          r.out_bag_count = q_nbags[0];
          r.last = (q_nbags[0] == 0);
          expected_beats.push_back(r);
          for (i = 0; i < q_nbags[0]; i++) begin
            r.out_bag_tag = q_bags[0][i];
            r.bag_valid = 1'b1;
            r.last = (i + 1 == q_nbags[0]);
            expected_beats.push_back(r);
          end
          for (i = 0; i + 1 < q_fill; i++) begin
            q_tag[i] = q_tag[i+1];
            q_pri[i] = q_pri[i+1];
            q_nbags[i] = q_nbags[i+1];
            q_bags[i] = q_bags[i+1];
          end
          q_fill--;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Driver: a request stays on the port until the block takes it. Each
  // accept edge feeds the prediction, then the next beat or an idle gap follows.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        predict_queue(in_req);
      end
      if (!start || !busy) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req <= pending_reqs.pop_front();
          start <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 4);
        end else begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed beat is compared with the oldest expected beat.
  always @(posedge clk) begin
    spq_res_t want;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_res.out_flight_tag), 64'(0));
      end else begin
        want = expected_beats.pop_front();
        if (out_res.status !== want.status)
          report_mismatch("status", 64'(out_res.status), 64'(want.status));
        if (out_res.out_flight_tag !== want.out_flight_tag)
          report_mismatch("flight tag", 64'(out_res.out_flight_tag),
                          64'(want.out_flight_tag));
        if (out_res.out_priority !== want.out_priority)
          report_mismatch("priority", 64'(out_res.out_priority), 64'(want.out_priority));
        if (out_res.out_bag_count !== want.out_bag_count)
          report_mismatch("bag count", 64'(out_res.out_bag_count),
                          64'(want.out_bag_count));
        if (out_res.out_bag_tag !== want.out_bag_tag)
          report_mismatch("bag tag", 64'(out_res.out_bag_tag), 64'(want.out_bag_tag));
        if (out_res.bag_valid !== want.bag_valid)
          report_mismatch("bag valid", 64'(out_res.bag_valid), 64'(want.bag_valid));
        if (out_res.last !== want.last)
          report_mismatch("last", 64'(out_res.last), 64'(want.last));
      end
    end
  end

  function automatic spq_req_t make_req(logic [1:0] kind, logic [31:0] tag,
                                        logic [3:0] pri, logic [31:0] bag);
    spq_req_t rq;
    rq.req_type = kind;
    rq.flight_tag = tag;
    rq.priority_req = pri;
    rq.bag_tag = bag;
    return rq;
  endfunction

  initial begin
    int n;
    int pick;
    logic [31:0] tags[$];
    logic [31:0] t;
    fail_count = 0;
    q_fill = 0;
    calm = 1'b0;
    stim_done = 1'b0;
    send_gap = 0;

    // Directed part: empty pop, unknown attach, ordering by priority with
    // ties, a full queue, a full bag list, extreme field values, and the
    // unused request code.
    pending_reqs.push_back(make_req(REQ_POP, '1, '1, '1));
    pending_reqs.push_back(make_req(REQ_ATTACH, 32'h0, 4'h0, 32'h1));
    pending_reqs.push_back(make_req(REQ_NONE, '1, '1, '1));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h0, 4'h0, 32'h0));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h5, 4'hF, 32'h0));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h0, 4'h7, 32'h0));
    for (n = 0; n < 4; n++)
      pending_reqs.push_back(make_req(REQ_INSERT, 32'h100 + n, 4'h7, 32'h0));
    pending_reqs.push_back(make_req(REQ_INSERT, 32'h200, 4'h1, 32'h0));
    for (n = 0; n < 9; n++)
      pending_reqs.push_back(make_req(REQ_ATTACH, 32'h0, 4'h0, 32'hA5A5_0000 + n));
    pending_reqs.push_back(make_req(REQ_ATTACH, 32'hFFFF_FFFF, 4'h0, 32'hFFFF_FFFF));
    for (n = 0; n < 9; n++)
      pending_reqs.push_back(make_req(REQ_POP, 32'h0, 4'h0, 32'h0));

    // Random part: mostly inserts and attaches to tags that are live (or were),
    // with pops keeping the queue swinging between empty and full.
    for (n = 0; n < 390; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        t = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
        tags.push_back(t);
        if (tags.size() > 16) void'(tags.pop_front());
        pending_reqs.push_back(make_req(REQ_INSERT, t, 4'($urandom_range(0, 15)),
                                        $urandom()));
      end else if (pick < 72) begin
        t = (tags.size() > 0 && $urandom_range(0, 7) != 0) ?
            tags[$urandom_range(0, tags.size() - 1)] : $urandom();
        pending_reqs.push_back(make_req(REQ_ATTACH, t, 4'($urandom()), $urandom()));
      end else if (pick < 97) begin
        pending_reqs.push_back(make_req(REQ_POP, $urandom(), 4'($urandom()), $urandom()));
      end else begin
        pending_reqs.push_back(make_req(REQ_NONE, $urandom(), 4'($urandom()), $urandom()));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_reqs.size() < 60);
    calm = 1'b1;
    wait (stim_done);
    wait (expected_beats.size() == 0);
    // A pop drains at most one header and all bags of an entry.
    repeat (BAGS + 6) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/stable_priority_queue_with_attachments.sv
sim/stable_priority_queue_with_attachments_test.sv
